### src/rn_pkg.sv
`timescale 1ns / 1ps

package rn_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int VALUE_W  = 10;
    localparam int SYMBOL_W = 7;
    localparam int DIGIT_W  = 4;
    localparam int REM_W    = 7;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1000;

    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic               err;
        logic               thousand;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } rn_item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SPLIT,
        F_PUSH
    } rn_front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } rn_back_state_t;

    typedef enum logic [1:0] {
        PL_HUND,
        PL_TENS,
        PL_UNITS
    } rn_place_t;

    // Number of letters that one decimal digit takes.
    function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] len;
        begin
            unique case (d)
                4'd0:    len = 3'd0;
                4'd1:    len = 3'd1;
                4'd2:    len = 3'd2;
                4'd3:    len = 3'd3;
                4'd4:    len = 3'd2;
                4'd5:    len = 3'd1;
                4'd6:    len = 3'd2;
                4'd7:    len = 3'd3;
                4'd8:    len = 3'd4;
                4'd9:    len = 3'd2;
                default: len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // Letter number k of digit d written at the given place.
    function automatic logic [SYMBOL_W-1:0] digit_letter(input rn_place_t p,
                                                         input logic [DIGIT_W-1:0] d,
                                                         input logic [1:0] k);
        logic [SYMBOL_W-1:0] one_s;
        logic [SYMBOL_W-1:0] five_s;
        logic [SYMBOL_W-1:0] ten_s;
        logic [SYMBOL_W-1:0] s;
        begin
            unique case (p)
                PL_HUND:
                begin
                    one_s  = SYM_C;
                    five_s = SYM_D;
                    ten_s  = SYM_M;
                end
                PL_TENS:
                begin
                    one_s  = SYM_X;
                    five_s = SYM_L;
                    ten_s  = SYM_C;
                end
                default:
                begin
                    one_s  = SYM_I;
                    five_s = SYM_V;
                    ten_s  = SYM_X;
                end
            endcase
            priority if (d == 4'd9)
                s = (k == 2'd0) ? one_s : ten_s;
            else if (d == 4'd4)
                s = (k == 2'd0) ? one_s : five_s;
            else if (d >= 4'd5)
                s = (k == 2'd0) ? five_s : one_s;
            else
                s = one_s;
            return s;
        end
    endfunction

endpackage

### src/integer_to_roman_numeral.sv
`timescale 1ns / 1ps

// Integer to Roman numeral converter. A request is taken when start is high and busy is low;
// value (1 to 1000) comes out as its Roman numeral in standard subtractive form, one ASCII
// letter per cycle on symbol with a gap for each zero digit passed over, marked by valid,
// most significant letter first, with last set on the final letter. Any other value gives a
// single result with error and last set and symbol zero. Results come on registered outputs
// and the receiver cannot stall them, so they must be taken in the cycle in which valid is
// high. The front end stays busy after each request while it splits the value into decimal
// digits and until its queue to the back end has room, so it takes no new request until the
// last one is pushed. The back end writes the letters of one number, passing over each zero
// digit before the last nonzero one, and returns to idle before it takes the next. The
// sustained rate is set by the slower of the two.
module integer_to_roman_numeral #(
    parameter int QUEUE_DEPTH = rn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rn_pkg::VALUE_W-1:0]      value,
    output logic                            valid,
    output logic [rn_pkg::SYMBOL_W-1:0]     symbol,
    output logic                            last,
    output logic                            error
);
    import rn_pkg::*;

    rn_item_t push_item;
    rn_item_t pop_item;
    logic     push;
    logic     full;
    logic     pop;
    logic     empty;

    rn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    rn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    rn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_item (pop_item),
        .pop      (pop),
        .valid    (valid),
        .symbol   (symbol),
        .last     (last),
        .error    (error)
    );

endmodule

### src/rn_front.sv
`timescale 1ns / 1ps

module rn_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rn_pkg::VALUE_W-1:0]      value,
    output logic                            busy,
    output logic                            push,
    output rn_pkg::rn_item_t                push_item,
    input  logic                            full
);
    import rn_pkg::*;

    rn_front_state_t      state_reg, state_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 err_reg, err_next;
    logic                 thou_reg, thou_next;
    logic [DIGIT_W-1:0]   hund_reg, hund_next;
    logic [REM_W-1:0]     rem_reg, rem_next;

    logic [DIGIT_W-1:0]   hund_c;
    logic [DIGIT_W-1:0]   tens_c;
    logic [DIGIT_W-1:0]   units_c;

    // Hundreds digit by parallel threshold compares, for values below 1000.
    always_comb
    begin
        hund_c = '0;
        for (int i = 1; i <= 9; i++)
        begin
            if (value_reg >= VALUE_W'(i * 100))
                hund_c = DIGIT_W'(i);
        end
    end

    always_comb
    begin
        tens_c = '0;
        for (int i = 1; i <= 9; i++)
        begin
            if (rem_reg >= REM_W'(i * 10))
                tens_c = DIGIT_W'(i);
        end
        units_c = DIGIT_W'(rem_reg - REM_W'(tens_c) * REM_W'(10));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        err_reg   <= err_next;
        thou_reg  <= thou_next;
        hund_reg  <= hund_next;
        rem_reg   <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        err_next   = err_reg;
        thou_next  = thou_reg;
        hund_next  = hund_reg;
        rem_next   = rem_reg;
        push       = 1'b0;
        busy       = (state_reg != F_IDLE);

        push_item.err      = err_reg;
        push_item.thousand = thou_reg;
        push_item.hund     = hund_reg;
        push_item.tens     = tens_c;
        push_item.units    = units_c;

        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    err_next   = (value == '0) || (value > VALUE_MAX);
                    thou_next  = (value == VALUE_MAX);
                    state_next = F_SPLIT;
                end
            end
            F_SPLIT:
            begin
                hund_next  = hund_c;
                rem_next   = REM_W'(value_reg - VALUE_W'(hund_c) * VALUE_W'(100));
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

### src/rn_queue.sv
`timescale 1ns / 1ps

module rn_queue #(
    parameter int DEPTH = rn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rn_pkg::rn_item_t push_item,
    output logic             full,
    input  logic             pop,
    output rn_pkg::rn_item_t pop_item,
    output logic             empty
);
    import rn_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rn_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### src/rn_back.sv
`timescale 1ns / 1ps

module rn_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  rn_pkg::rn_item_t                pop_item,
    output logic                            pop,
    output logic                            valid,
    output logic [rn_pkg::SYMBOL_W-1:0]     symbol,
    output logic                            last,
    output logic                            error
);
    import rn_pkg::*;

    rn_back_state_t        state_reg, state_next;
    rn_item_t              item_reg, item_next;
    rn_place_t             place_reg, place_next;
    logic [1:0]            k_reg, k_next;
    logic                  valid_reg, valid_next;
    logic [SYMBOL_W-1:0]   symbol_reg, symbol_next;
    logic                  last_reg, last_next;
    logic                  error_reg, error_next;

    logic [DIGIT_W-1:0]    digit;
    logic [2:0]            len;
    logic                  more_after;
    rn_place_t             place_adv;

    always_comb
    begin
        unique case (place_reg)
            PL_HUND:
            begin
                digit      = item_reg.hund;
                more_after = (item_reg.tens != '0) || (item_reg.units != '0);
                place_adv  = PL_TENS;
            end
            PL_TENS:
            begin
                digit      = item_reg.tens;
                more_after = (item_reg.units != '0);
                place_adv  = PL_UNITS;
            end
            default:
            begin
                digit      = item_reg.units;
                more_after = 1'b0;
                place_adv  = PL_UNITS;
            end
        endcase
        len = digit_len(digit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        place_reg  <= place_next;
        k_reg      <= k_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        place_next  = place_reg;
        k_next      = k_reg;
        valid_next  = 1'b0;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        error_next  = error_reg;
        pop         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    item_next  = pop_item;
                    place_next = PL_HUND;
                    k_next     = '0;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                priority if (item_reg.err)
                begin
                    valid_next  = 1'b1;
                    symbol_next = SYM_NONE;
                    last_next   = 1'b1;
                    error_next  = 1'b1;
                    state_next  = B_IDLE;
                end
                else if (item_reg.thousand)
                begin
                    valid_next  = 1'b1;
                    symbol_next = SYM_M;
                    last_next   = 1'b1;
                    error_next  = 1'b0;
                    state_next  = B_IDLE;
                end
                else if (len == '0)
                begin
                    // A zero digit writes nothing; move on to the next place.
                    place_next = place_adv;
                end
                else
                begin
                    valid_next  = 1'b1;
                    symbol_next = digit_letter(place_reg, digit, k_reg);
                    error_next  = 1'b0;
                    last_next   = 1'b0;
                    if ({1'b0, k_reg} == len - 3'd1)
                    begin
                        k_next = '0;
                        if (more_after)
                        begin
                            place_next = place_adv;
                        end
                        else
                        begin
                            last_next  = 1'b1;
                            state_next = B_IDLE;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign valid  = valid_reg;
    assign symbol = symbol_reg;
    assign last   = last_reg;
    assign error  = error_reg;

endmodule
